### design/ddp_pkg.sv
// Shared types and constants for the dust density post-processing block.
// Used by ddp_ctrl, ddp_dpath and dust_density_postprocess; depends on nothing.
package ddp_pkg;

   localparam int SampleWidth   = 16;
   localparam int FiltWidth     = 24;
   localparam int AlphaWidth    = 9;
   localparam int FracBits      = 8;
   localparam int DivSteps      = 16;
   localparam int DivCntWidth   = 4;

   localparam logic [AlphaWidth-1:0] AlphaMin  = 9'd3;
   localparam logic [AlphaWidth-1:0] AlphaMax  = 9'd256;
   localparam logic [AlphaWidth-1:0] AlphaOne  = 9'd256;

   // Band edges of the air quality index, in ug/m3.
   localparam logic [SampleWidth-1:0] BandEdge1 = 16'd35;
   localparam logic [SampleWidth-1:0] BandEdge2 = 16'd75;
   localparam logic [SampleWidth-1:0] BandEdge3 = 16'd115;
   localparam logic [SampleWidth-1:0] BandEdge4 = 16'd150;
   localparam logic [SampleWidth-1:0] BandEdge5 = 16'd250;

   localparam logic [2:0] BandGoodMax = 3'd2;

   // Register reset values.
   localparam logic [2:0]             FeatReset      = 3'd0;
   localparam logic [AlphaWidth-1:0]  AlphaReset     = 9'd26;
   localparam logic [SampleWidth-1:0] DensMinReset   = 16'd0;
   localparam logic [SampleWidth-1:0] DensMaxReset   = 16'd500;
   localparam logic [SampleWidth-1:0] OutMinReset    = 16'd0;
   localparam logic [SampleWidth-1:0] OutMaxReset    = 16'd100;
   localparam logic [SampleWidth-1:0] ThresholdReset = 16'd200;

   typedef enum logic [2:0] {
      CSR_FEATURE_ENABLES   = 3'd0,
      CSR_FILTER_ALPHA      = 3'd1,
      CSR_CALIB_DENSITY_MIN = 3'd2,
      CSR_CALIB_DENSITY_MAX = 3'd3,
      CSR_CALIB_OUT_MIN     = 3'd4,
      CSR_CALIB_OUT_MAX     = 3'd5,
      CSR_ALERT_THRESHOLD   = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_NEW,
      ST_MUL_OLD,
      ST_UPDATE,
      ST_CLAMP,
      ST_SCALE,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [2:0]             feature_enables;
      logic [AlphaWidth-1:0]  filter_alpha;
      logic [SampleWidth-1:0] density_min;
      logic [SampleWidth-1:0] density_max;
      logic [SampleWidth-1:0] out_min;
      logic [SampleWidth-1:0] out_max;
      logic [SampleWidth-1:0] threshold;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic mul_new;
      logic mul_old;
      logic update;
      logic clamp;
      logic scale;
      logic div_step;
      logic result;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic [2:0] band_of(input logic [SampleWidth-1:0] d);
      logic [2:0] band;
      if (d <= BandEdge1)      band = 3'd1;
      else if (d <= BandEdge2) band = 3'd2;
      else if (d <= BandEdge3) band = 3'd3;
      else if (d <= BandEdge4) band = 3'd4;
      else if (d <= BandEdge5) band = 3'd5;
      else                     band = 3'd6;
      return band;
   endfunction

endpackage

### design/ddp_ctrl.sv
// Sequencer for the dust density post-processing block.
// Steps the datapath through filter, clamp, scale and the serial divide.
// Depends on ddp_pkg.
module ddp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ddp_pkg::status_type status,
   output ddp_pkg::cmd_type    cmd
);

   ddp_pkg::state_type state_ff, state_in;
   logic [ddp_pkg::DivCntWidth-1:0] cnt_ff, cnt_in;
   logic div_last;

   assign div_last = (cnt_ff == ddp_pkg::DivCntWidth'(ddp_pkg::DivSteps - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ddp_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ddp_pkg::ST_IDLE: begin
            if (req_valid) state_in = ddp_pkg::ST_MUL_NEW;
         end
         ddp_pkg::ST_MUL_NEW: state_in = ddp_pkg::ST_MUL_OLD;
         ddp_pkg::ST_MUL_OLD: state_in = ddp_pkg::ST_UPDATE;
         ddp_pkg::ST_UPDATE:  state_in = ddp_pkg::ST_CLAMP;
         ddp_pkg::ST_CLAMP:   state_in = ddp_pkg::ST_SCALE;
         ddp_pkg::ST_SCALE: begin
            state_in = ddp_pkg::ST_DIVIDE;
            cnt_in   = '0;
         end
         ddp_pkg::ST_DIVIDE: begin
            cnt_in = cnt_ff + 1'b1;
            if (div_last) state_in = ddp_pkg::ST_RESULT;
         end
         ddp_pkg::ST_RESULT: begin
            if (status.out_free) state_in = ddp_pkg::ST_IDLE;
         end
         default: state_in = ddp_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ddp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ddp_pkg::ST_MUL_NEW: cmd.mul_new  = 1'b1;
         ddp_pkg::ST_MUL_OLD: cmd.mul_old  = 1'b1;
         ddp_pkg::ST_UPDATE:  cmd.update   = 1'b1;
         ddp_pkg::ST_CLAMP:   cmd.clamp    = 1'b1;
         ddp_pkg::ST_SCALE:   cmd.scale    = 1'b1;
         ddp_pkg::ST_DIVIDE:  cmd.div_step = 1'b1;
         ddp_pkg::ST_RESULT:  cmd.result   = status.out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### design/ddp_dpath.sv
// Datapath of the dust density post-processing block: filter state, one
// multiplier per step, a 16-step restoring divider and the result register.
// Depends on ddp_pkg.
module ddp_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  ddp_pkg::cfg_type       cfg,
   input  ddp_pkg::cmd_type       cmd,
   output ddp_pkg::status_type    status,
   input  logic [15:0]            sample_density,
   input  logic                   restart_filter,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [23:0]            filtered_density,
   output logic [2:0]             quality_index,
   output logic                   quality_good,
   output logic [15:0]            calibrated_value,
   output logic                   alert
);

   logic [15:0] x_ff;
   logic [23:0] filt_ff, filt_in;
   logic        loaded_ff, loaded_in;
   logic [32:0] prod_new_ff, prod_old_ff;
   logic [23:0] d_ff;
   logic [23:0] rem_ff, rem_in;
   logic [15:0] numlo_ff, numlo_in;
   logic [15:0] quo_ff, quo_in;

   logic        rsp_valid_ff;
   logic [23:0] rsp_filt_ff;
   logic [2:0]  rsp_band_ff;
   logic        rsp_good_ff;
   logic [15:0] rsp_cal_ff;
   logic        rsp_alert_ff;

   logic [8:0]  alpha;
   logic [8:0]  alpha_rest;
   logic [23:0] xq;
   logic [33:0] acc;
   logic [23:0] work;
   logic [23:0] lo, hi, span;
   logic        empty;
   logic        decreasing;
   logic [15:0] range;
   logic [39:0] scaled;
   logic [24:0] trial;
   logic        trial_ge;
   logic [24:0] trial_diff;
   logic [2:0]  band;
   logic [15:0] cal;

   always_comb begin
      if (cfg.filter_alpha < ddp_pkg::AlphaMin)      alpha = ddp_pkg::AlphaMin;
      else if (cfg.filter_alpha > ddp_pkg::AlphaMax) alpha = ddp_pkg::AlphaMax;
      else                                           alpha = cfg.filter_alpha;
   end

   assign alpha_rest = ddp_pkg::AlphaOne - alpha;
   assign xq         = {x_ff, 8'h00};
   assign acc        = {1'b0, prod_new_ff} + {1'b0, prod_old_ff} + 34'd128;
   assign work       = cfg.feature_enables[0] ? filt_ff : xq;

   assign lo         = {cfg.density_min, 8'h00};
   assign hi         = {cfg.density_max, 8'h00};
   assign span       = hi - lo;
   assign empty      = (cfg.density_max <= cfg.density_min);
   assign decreasing = (cfg.out_max < cfg.out_min);
   assign range      = decreasing ? (cfg.out_min - cfg.out_max) : (cfg.out_max - cfg.out_min);
   assign scaled     = d_ff * range;

   assign trial      = {rem_ff, numlo_ff[15]};
   assign trial_ge   = (trial >= {1'b0, span});
   assign trial_diff = trial - {1'b0, span};

   assign band = ddp_pkg::band_of(x_ff);

   always_comb begin
      if (!cfg.feature_enables[1])  cal = '0;
      else if (empty)               cal = cfg.out_min;
      else if (decreasing)          cal = cfg.out_min - quo_ff;
      else                          cal = cfg.out_min + quo_ff;
   end

   // Filter state: a restart clears it as the request is taken.
   always_comb begin
      filt_in   = filt_ff;
      loaded_in = loaded_ff;
      if (cmd.load && restart_filter) begin
         filt_in   = '0;
         loaded_in = 1'b0;
      end else if (cmd.update && cfg.feature_enables[0]) begin
         filt_in   = loaded_ff ? acc[31:8] : xq;
         loaded_in = 1'b1;
      end
   end

   always_comb begin
      rem_in   = rem_ff;
      numlo_in = numlo_ff;
      quo_in   = quo_ff;
      if (cmd.scale) begin
         rem_in   = scaled[39:16];
         numlo_in = scaled[15:0];
         quo_in   = '0;
      end else if (cmd.div_step) begin
         rem_in   = trial_ge ? trial_diff[23:0] : trial[23:0];
         numlo_in = {numlo_ff[14:0], 1'b0};
         quo_in   = {quo_ff[14:0], trial_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff      <= '0;
         loaded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         filt_ff   <= filt_in;
         loaded_ff <= loaded_in;
         if (cmd.result)     rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load)    x_ff        <= sample_density;
      if (cmd.mul_new) prod_new_ff <= alpha * xq;
      if (cmd.mul_old) prod_old_ff <= alpha_rest * filt_ff;
      if (cmd.clamp) begin
         if (work <= lo)      d_ff <= '0;
         else if (work >= hi) d_ff <= span;
         else                 d_ff <= work - lo;
      end
      rem_ff   <= rem_in;
      numlo_ff <= numlo_in;
      quo_ff   <= quo_in;
      if (cmd.result) begin
         rsp_filt_ff  <= filt_ff;
         rsp_band_ff  <= band;
         rsp_good_ff  <= (band <= ddp_pkg::BandGoodMax);
         rsp_cal_ff   <= cal;
         rsp_alert_ff <= cfg.feature_enables[2] && (work > {cfg.threshold, 8'h00});
      end
   end

   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign filtered_density = rsp_filt_ff;
   assign quality_index    = rsp_band_ff;
   assign quality_good     = rsp_good_ff;
   assign calibrated_value = rsp_cal_ff;
   assign alert            = rsp_alert_ff;

endmodule

### design/dust_density_postprocess.sv
// Top level of the dust density post-processing block: register file,
// sequencer and datapath. Depends on ddp_pkg, ddp_ctrl and ddp_dpath.
//
//   Channel  Direction  Handshake             Payload
//   req_     in         req_tvalid/tready     tdata: sample_density; tuser: restart_filter
//   rsp_     out        rsp_tvalid/tready     tdata: filtered, index, calibrated; tuser: flags
//   csr_     in         csr_valid/csr_ready   csr_index, csr_data
//
// After acceptance a request runs the multiply, update, clamp and scale steps and then
// the 16-step restoring divider of the calibration map before its response is loaded.
// One request is in work at a time; the next is accepted the cycle after the
// response register is loaded, even while that response still waits.
// Reset is synchronous; it clears the filter and the response and resets the registers.
// A stalled response holds the sequencer in its last step until taken.
module dust_density_postprocess (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample_density
   input  logic [0:0]  req_tuser,   // [0] restart_filter
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [23:0] filtered_density, [26:24] quality_index,
                                    // [42:27] calibrated_value, [47:43] zero
   output logic [1:0]  rsp_tuser,   // [0] quality_good, [1] alert
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   ddp_pkg::cfg_type    cfg_ff;
   ddp_pkg::cmd_type    cmd;
   ddp_pkg::status_type status;

   logic [23:0] filtered_density;
   logic [2:0]  quality_index;
   logic        quality_good;
   logic [15:0] calibrated_value;
   logic        alert;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.feature_enables <= ddp_pkg::FeatReset;
         cfg_ff.filter_alpha    <= ddp_pkg::AlphaReset;
         cfg_ff.density_min     <= ddp_pkg::DensMinReset;
         cfg_ff.density_max     <= ddp_pkg::DensMaxReset;
         cfg_ff.out_min         <= ddp_pkg::OutMinReset;
         cfg_ff.out_max         <= ddp_pkg::OutMaxReset;
         cfg_ff.threshold       <= ddp_pkg::ThresholdReset;
      end else if (csr_valid && csr_ready) begin
         case (ddp_pkg::csr_index_type'(csr_index))
            ddp_pkg::CSR_FEATURE_ENABLES:   cfg_ff.feature_enables <= csr_data[2:0];
            ddp_pkg::CSR_FILTER_ALPHA:      cfg_ff.filter_alpha    <= csr_data[8:0];
            ddp_pkg::CSR_CALIB_DENSITY_MIN: cfg_ff.density_min     <= csr_data;
            ddp_pkg::CSR_CALIB_DENSITY_MAX: cfg_ff.density_max     <= csr_data;
            ddp_pkg::CSR_CALIB_OUT_MIN:     cfg_ff.out_min         <= csr_data;
            ddp_pkg::CSR_CALIB_OUT_MAX:     cfg_ff.out_max         <= csr_data;
            ddp_pkg::CSR_ALERT_THRESHOLD:   cfg_ff.threshold       <= csr_data;
            default: begin
            end
         endcase
      end
   end

   ddp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   ddp_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd              (cmd),
      .status           (status),
      .sample_density   (req_tdata),
      .restart_filter   (req_tuser[0]),
      .rsp_ready        (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .filtered_density (filtered_density),
      .quality_index    (quality_index),
      .quality_good     (quality_good),
      .calibrated_value (calibrated_value),
      .alert            (alert)
   );

   assign rsp_tdata = {5'b0, calibrated_value, quality_index, filtered_density};
   assign rsp_tuser = {alert, quality_good};

`ifndef SYNTH
   // Once a request is taken, no other is taken until its response is built.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in work");

   // The index of a response is always one of the six bands.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[26:24] != 3'd0 && rsp_tdata[26:24] != 3'd7))
      else $error("quality index out of range");

   // The good-air flag agrees with the band it came from.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tdata[26:24] <= ddp_pkg::BandGoodMax)))
      else $error("good-air flag disagrees with quality index");

   // No alert is raised while alerts are disabled.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> cfg_ff.feature_enables[2])
      else $error("alert raised while disabled");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for dust_density_postprocess. A directed table runs first, then
// random phases; each response is checked against a known table result or an in-bench model.
// Depends on ddp_pkg and the RTL.
module testbench;

   localparam int unsigned CycleLimit   = 400000;
   localparam int unsigned HoldCycles   = 300;
   localparam int unsigned SettleCycles = 40;
   localparam int unsigned RandomPhases = 11;
   localparam int unsigned PhaseItems   = 50;
   localparam int unsigned MaxReports   = 10;

   localparam int FeatFilter = 0;
   localparam int FeatCalib  = 1;
   localparam int FeatAlert  = 2;
   localparam logic [2:0] FeatAll     = 3'b111;
   localparam logic [2:0] CsrUnmapped = 3'd7;

   localparam logic [15:0] BandTies [10] = '{16'd35, 16'd36, 16'd75, 16'd76, 16'd115,
                                             16'd116, 16'd150, 16'd151, 16'd250, 16'd251};

   typedef struct packed {
      logic [23:0] filtered;
      logic [2:0]  band;
      logic        good;
      logic [15:0] calibrated;
      logic        alert;
   } dust_result_type;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_KNOWN, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      logic [2:0]      index;
      logic [15:0]     value;
      logic            restart;
      dust_result_type known;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // Shadow copy of the register file and the filter state.
   logic [2:0]  sh_enables   = ddp_pkg::FeatReset;
   logic [8:0]  sh_alpha     = ddp_pkg::AlphaReset;
   logic [15:0] sh_dens_lo   = ddp_pkg::DensMinReset;
   logic [15:0] sh_dens_hi   = ddp_pkg::DensMaxReset;
   logic [15:0] sh_out_lo    = ddp_pkg::OutMinReset;
   logic [15:0] sh_out_hi    = ddp_pkg::OutMaxReset;
   logic [15:0] sh_threshold = ddp_pkg::ThresholdReset;
   logic [23:0] filt_state   = '0;
   logic        filt_primed  = 1'b0;

   dust_result_type pending_results [$];
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  holds_asked = 0;
   int unsigned  holds_done = 0;
   int unsigned  hold_left = 0;
   bit           gaps_on = 1'b1;

   dust_density_postprocess i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void apply_write(input logic [2:0] idx, input logic [15:0] data);
      case (idx)
         ddp_pkg::CSR_FEATURE_ENABLES:   sh_enables   = data[2:0];
         ddp_pkg::CSR_FILTER_ALPHA:      sh_alpha     = data[8:0];
         ddp_pkg::CSR_CALIB_DENSITY_MIN: sh_dens_lo   = data;
         ddp_pkg::CSR_CALIB_DENSITY_MAX: sh_dens_hi   = data;
         ddp_pkg::CSR_CALIB_OUT_MIN:     sh_out_lo    = data;
         ddp_pkg::CSR_CALIB_OUT_MAX:     sh_out_hi    = data;
         ddp_pkg::CSR_ALERT_THRESHOLD:   sh_threshold = data;
         default: ;
      endcase
   endfunction

   // Clamp to the density span, then scale; the quotient truncates toward out_min.
   function automatic logic [15:0] calib_map(input logic [23:0] work);
      logic [63:0] lo, hi, span, offs, q;
      if (sh_dens_hi <= sh_dens_lo) return sh_out_lo;
      lo = 64'(sh_dens_lo) << ddp_pkg::FracBits;
      hi = 64'(sh_dens_hi) << ddp_pkg::FracBits;
      span = hi - lo;
      if (64'(work) <= lo) offs = '0;
      else if (64'(work) >= hi) offs = span;
      else offs = 64'(work) - lo;
      if (sh_out_hi >= sh_out_lo) begin
         q = offs * 64'(sh_out_hi - sh_out_lo) / span;
         return sh_out_lo + q[15:0];
      end
      q = offs * 64'(sh_out_lo - sh_out_hi) / span;
      return sh_out_lo - q[15:0];
   endfunction

   function automatic dust_result_type predict_dust(input logic [15:0] sample,
                                                    input logic restart);
      dust_result_type r;
      logic [23:0]  scaled, work;
      logic [63:0]  weight, acc;
      scaled = {sample, 8'h00};
      if (restart) begin
         filt_state = '0;
         filt_primed = 1'b0;
      end
      if (sh_enables[FeatFilter]) begin
         if (!filt_primed) begin
            filt_state = scaled;
         end else begin
            weight = (sh_alpha < ddp_pkg::AlphaMin) ? 64'(ddp_pkg::AlphaMin) :
                     (sh_alpha > ddp_pkg::AlphaMax) ? 64'(ddp_pkg::AlphaMax) : 64'(sh_alpha);
            // The added half LSB rounds the blend up at the tie.
            acc = weight * 64'(scaled) +
                  (64'(ddp_pkg::AlphaOne) - weight) * 64'(filt_state) + 64'd128;
            filt_state = acc[31:8];
         end
         filt_primed = 1'b1;
         work = filt_state;
      end else begin
         work = scaled;
      end
      r.filtered = filt_state;
      if (sample <= ddp_pkg::BandEdge1) r.band = 3'd1;
      else if (sample <= ddp_pkg::BandEdge2) r.band = 3'd2;
      else if (sample <= ddp_pkg::BandEdge3) r.band = 3'd3;
      else if (sample <= ddp_pkg::BandEdge4) r.band = 3'd4;
      else if (sample <= ddp_pkg::BandEdge5) r.band = 3'd5;
      else r.band = 3'd6;
      r.good = (r.band <= ddp_pkg::BandGoodMax);
      r.calibrated = sh_enables[FeatCalib] ? calib_map(work) : 16'd0;
      r.alert = sh_enables[FeatAlert] && (work > {sh_threshold, 8'h00});
      return r;
   endfunction

   function automatic stim_row_type sample_row(input logic [15:0] sample, input logic restart);
      stim_row_type r;
      r = '0;
      r.kind = ROW_PREDICT;
      r.value = sample;
      r.restart = restart;
      return r;
   endfunction

   function automatic stim_row_type known_row(input logic [15:0] sample, input logic restart,
                                              input logic [23:0] filtered,
                                              input logic [2:0] band,
                                              input logic good, input logic [15:0] calibrated,
                                              input logic alert);
      stim_row_type r;
      r = '0;
      r.kind = ROW_KNOWN;
      r.value = sample;
      r.restart = restart;
      r.known = '{filtered, band, good, calibrated, alert};
      return r;
   endfunction

   function automatic stim_row_type write_row(input logic [2:0] idx, input logic [15:0] data);
      stim_row_type r;
      r = '0;
      r.kind = ROW_WRITE;
      r.index = idx;
      r.value = data;
      return r;
   endfunction

   task automatic note_mismatch(input string what, input longint unsigned want,
                                input longint unsigned got);
      mismatch_count++;
      if (mismatch_count <= MaxReports) begin
         $display("mismatch at cycle %0d: %s expected 0x%0h actual 0x%0h",
                  cycle_count, what, want, got);
      end
   endtask

   // The caller lowers csr_valid once a batch of writes is done.
   task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_write(idx, data);
   endtask

   // Leaves req_tvalid high after the handshake so the next request can follow directly.
   task automatic send_request(input logic [15:0] sample, input logic restart,
                               input logic typed, input dust_result_type known);
      dust_result_type predicted;
      if (gaps_on && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
      predicted = predict_dust(sample, restart);
      pending_results.push_back(typed ? known : predicted);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_side
      dust_result_type expected;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            note_mismatch("response with nothing pending", 0, rsp_tdata);
         end else begin
            expected = pending_results.pop_front();
            if (rsp_tdata[23:0] !== expected.filtered)
               note_mismatch("filtered_density", expected.filtered, rsp_tdata[23:0]);
            if (rsp_tdata[26:24] !== expected.band)
               note_mismatch("quality_index", expected.band, rsp_tdata[26:24]);
            if (rsp_tdata[42:27] !== expected.calibrated)
               note_mismatch("calibrated_value", expected.calibrated, rsp_tdata[42:27]);
            if (rsp_tdata[47:43] !== 5'd0)
               note_mismatch("tdata padding", 0, rsp_tdata[47:43]);
            if (rsp_tuser[0] !== expected.good)
               note_mismatch("quality_good", expected.good, rsp_tuser[0]);
            if (rsp_tuser[1] !== expected.alert)
               note_mismatch("alert", expected.alert, rsp_tuser[1]);
         end
      end
      // A long hold lets the block fill up and back-pressure the request side.
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done <= holds_done + 1;
         hold_left <= HoldCycles;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(gaps_on && $urandom_range(99) < 35);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type directed_rows [$];
      stim_row_type row;
      logic [15:0] word, dens_lo, dens_hi, sample;
      logic        restart;

      // Right after reset every feature is off, so only the bands change.
      directed_rows.push_back(known_row(16'd0,     1'b0, 24'h0, 3'd1, 1'b1, 16'd0, 1'b0));
      directed_rows.push_back(known_row(16'd35,    1'b0, 24'h0, 3'd1, 1'b1, 16'd0, 1'b0));
      directed_rows.push_back(known_row(16'd36,    1'b0, 24'h0, 3'd2, 1'b1, 16'd0, 1'b0));
      directed_rows.push_back(known_row(16'd75,    1'b0, 24'h0, 3'd2, 1'b1, 16'd0, 1'b0));
      directed_rows.push_back(known_row(16'd76,    1'b0, 24'h0, 3'd3, 1'b0, 16'd0, 1'b0));
      directed_rows.push_back(known_row(16'd115,   1'b0, 24'h0, 3'd3, 1'b0, 16'd0, 1'b0));
      directed_rows.push_back(known_row(16'd116,   1'b0, 24'h0, 3'd4, 1'b0, 16'd0, 1'b0));
      directed_rows.push_back(known_row(16'd150,   1'b0, 24'h0, 3'd4, 1'b0, 16'd0, 1'b0));
      directed_rows.push_back(known_row(16'd151,   1'b0, 24'h0, 3'd5, 1'b0, 16'd0, 1'b0));
      directed_rows.push_back(known_row(16'd250,   1'b0, 24'h0, 3'd5, 1'b0, 16'd0, 1'b0));
      directed_rows.push_back(known_row(16'd251,   1'b0, 24'h0, 3'd6, 1'b0, 16'd0, 1'b0));
      directed_rows.push_back(known_row(16'hFFFF,  1'b1, 24'h0, 3'd6, 1'b0, 16'd0, 1'b0));
      directed_rows.push_back(write_row(ddp_pkg::CSR_FEATURE_ENABLES, 16'hFFFF));
      directed_rows.push_back(known_row(16'hFFFF, 1'b0, 24'hFFFF00, 3'd6, 1'b0, 16'd100, 1'b1));
      directed_rows.push_back(sample_row(16'd0, 1'b0));
      directed_rows.push_back(sample_row(16'd100, 1'b1));
      directed_rows.push_back(write_row(ddp_pkg::CSR_FILTER_ALPHA, 16'd0));
      directed_rows.push_back(sample_row(16'hFFFF, 1'b0));
      directed_rows.push_back(write_row(ddp_pkg::CSR_FILTER_ALPHA, 16'hFFFF));
      directed_rows.push_back(sample_row(16'd1234, 1'b0));
      directed_rows.push_back(write_row(ddp_pkg::CSR_CALIB_DENSITY_MIN, 16'd1000));
      directed_rows.push_back(write_row(ddp_pkg::CSR_CALIB_DENSITY_MAX, 16'd1000));
      directed_rows.push_back(write_row(ddp_pkg::CSR_CALIB_OUT_MIN, 16'd777));
      directed_rows.push_back(write_row(ddp_pkg::CSR_CALIB_OUT_MAX, 16'hFFFF));
      directed_rows.push_back(write_row(ddp_pkg::CSR_ALERT_THRESHOLD, 16'hFFFF));
      directed_rows.push_back(known_row(16'd5000, 1'b0, 24'h138800, 3'd6, 1'b0, 16'd777, 1'b0));
      directed_rows.push_back(write_row(ddp_pkg::CSR_CALIB_DENSITY_MAX, 16'd0));
      directed_rows.push_back(sample_row(16'd0, 1'b0));
      directed_rows.push_back(write_row(ddp_pkg::CSR_CALIB_DENSITY_MIN, 16'd0));
      directed_rows.push_back(write_row(ddp_pkg::CSR_CALIB_DENSITY_MAX, 16'hFFFF));
      directed_rows.push_back(write_row(ddp_pkg::CSR_CALIB_OUT_MIN, 16'hFFFF));
      directed_rows.push_back(write_row(ddp_pkg::CSR_CALIB_OUT_MAX, 16'd0));
      directed_rows.push_back(write_row(ddp_pkg::CSR_ALERT_THRESHOLD, 16'd0));
      directed_rows.push_back(sample_row(16'hFFFF, 1'b1));
      directed_rows.push_back(sample_row(16'd0, 1'b0));
      directed_rows.push_back(sample_row(16'd1, 1'b0));
      directed_rows.push_back(write_row(ddp_pkg::CSR_FEATURE_ENABLES, 16'(1 << FeatCalib)));
      directed_rows.push_back(sample_row(16'd32768, 1'b0));
      directed_rows.push_back(write_row(ddp_pkg::CSR_FEATURE_ENABLES, 16'(1 << FeatAlert)));
      directed_rows.push_back(write_row(ddp_pkg::CSR_ALERT_THRESHOLD, 16'hFFFF));
      directed_rows.push_back(sample_row(16'hFFFF, 1'b0));
      directed_rows.push_back(write_row(ddp_pkg::CSR_ALERT_THRESHOLD, 16'hFFFE));
      directed_rows.push_back(sample_row(16'hFFFF, 1'b0));
      directed_rows.push_back(write_row(CsrUnmapped, 16'hFFFF));
      directed_rows.push_back(write_row(ddp_pkg::CSR_FEATURE_ENABLES, 16'(1 << FeatFilter)));
      directed_rows.push_back(sample_row(16'd42, 1'b0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         if (row.kind == ROW_WRITE) begin
            wait_idle();
            write_register(row.index, row.value);
         end else begin
            csr_valid <= 1'b0;
            send_request(row.value, row.restart, row.kind == ROW_KNOWN, row.known);
         end
      end

      for (int phase = 0; phase < RandomPhases; phase++) begin
         wait_idle();
         gaps_on <= (phase != 3);
         if (phase == 6) holds_asked <= holds_asked + 1;
         case (phase)
            0: begin
               write_register(ddp_pkg::CSR_FEATURE_ENABLES, 16'hFFFF);
               write_register(ddp_pkg::CSR_FILTER_ALPHA, 16'd0);
               write_register(ddp_pkg::CSR_CALIB_DENSITY_MIN, 16'd0);
               write_register(ddp_pkg::CSR_CALIB_DENSITY_MAX, 16'hFFFF);
               write_register(ddp_pkg::CSR_CALIB_OUT_MIN, 16'd0);
               write_register(ddp_pkg::CSR_CALIB_OUT_MAX, 16'hFFFF);
               write_register(ddp_pkg::CSR_ALERT_THRESHOLD, 16'd0);
            end
            1: begin
               write_register(ddp_pkg::CSR_FILTER_ALPHA, 16'hFFFF);
               write_register(ddp_pkg::CSR_CALIB_DENSITY_MIN, 16'hFFFE);
               write_register(ddp_pkg::CSR_CALIB_OUT_MIN, 16'hFFFF);
               write_register(ddp_pkg::CSR_CALIB_OUT_MAX, 16'd0);
               write_register(ddp_pkg::CSR_ALERT_THRESHOLD, 16'hFFFF);
            end
            default: begin
               if ($urandom_range(0, 2) != 0) begin
                  word = 16'($urandom_range(0, 65535));
                  if ($urandom_range(0, 1)) word[2:0] = FeatAll;
                  write_register(ddp_pkg::CSR_FEATURE_ENABLES, word);
               end
               if ($urandom_range(0, 2) != 0) begin
                  case ($urandom_range(0, 4))
                     0: word = 16'($urandom_range(0, 2));
                     1: word = 16'($urandom_range(3, 256));
                     2: word = 16'($urandom_range(257, 511));
                     3: word = 16'($urandom_range(0, 65535));
                     default: word = 16'($urandom_range(3, 40));
                  endcase
                  write_register(ddp_pkg::CSR_FILTER_ALPHA, word);
               end
               if ($urandom_range(0, 2) != 0) begin
                  dens_lo = 16'($urandom_range(0, 400));
                  case ($urandom_range(0, 3))
                     0: dens_hi = dens_lo + 16'($urandom_range(1, 1500));
                     1: dens_hi = 16'($urandom_range(0, 65535));
                     2: dens_hi = dens_lo;
                     default: dens_hi = dens_lo + 16'($urandom_range(1, 300));
                  endcase
                  write_register(ddp_pkg::CSR_CALIB_DENSITY_MIN, dens_lo);
                  write_register(ddp_pkg::CSR_CALIB_DENSITY_MAX, dens_hi);
               end
               if ($urandom_range(0, 2) != 0) begin
                  write_register(ddp_pkg::CSR_CALIB_OUT_MIN, 16'($urandom_range(0, 65535)));
                  write_register(ddp_pkg::CSR_CALIB_OUT_MAX, 16'($urandom_range(0, 65535)));
               end
               if ($urandom_range(0, 2) != 0) begin
                  word = $urandom_range(0, 1) ? 16'($urandom_range(0, 400))
                                               : 16'($urandom_range(0, 65535));
                  write_register(ddp_pkg::CSR_ALERT_THRESHOLD, word);
               end
               if ($urandom_range(0, 3) == 0) begin
                  write_register(CsrUnmapped, 16'($urandom_range(0, 65535)));
               end
            end
         endcase
         csr_valid <= 1'b0;

         repeat (PhaseItems) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: sample = 16'($urandom_range(0, 300));
               4: sample = BandTies[$urandom_range(0, 9)];
               5, 6, 7: sample = 16'($urandom_range(0, 65535));
               8: sample = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               default: sample = 16'($urandom_range(0, 3000));
            endcase
            restart = ($urandom_range(0, 9) == 0);
            send_request(sample, restart, 1'b0, '0);
         end
      end

      wait_idle();
      repeat (SettleCycles) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
